@@ rtl/core/bb3_pkg.sv @@
// Shared types, constants and arithmetic helpers of the 3x3 RGB box blur.
`timescale 1ns / 1ps

package bb3_pkg;

  // Largest image the line store supports.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and register widths.
  localparam int CH_W      = 8;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int DATA_W    = 3 * CH_W;

  // Counter widths.  The input row runs up to the height plus one while draining.
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int IN_ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int EW_W     = $clog2(MAX_WIDTH + 1);
  localparam int EH_W     = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW_W   = (DIM_W > EW_W) ? DIM_W : EW_W;
  localparam int CMPH_W   = (DIM_W > EH_W) ? DIM_W : EH_W;

  // Window sum and divider widths.
  localparam int SUM_W     = $clog2(9 * 255 + 1);
  localparam int CNT_W     = 4;
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_MUL_W = 13;
  localparam int PROD_W    = NUM_W - 1 + DIV_MUL_W;
  localparam int DIV3_SH   = 14;
  localparam int DIV9_SH   = 16;
  localparam logic [DIV_MUL_W-1:0] DIV3_MUL = 13'd5462;
  localparam logic [DIV_MUL_W-1:0] DIV9_MUL = 13'd7282;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0]     FRAME_DIM_RESET  = 11'd1024;

  // Input beat kind carried on tuser.
  localparam logic MODE_PIXEL = 1'b0;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // One line store entry: the row two above and the row just above.
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_ent_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_trip_t;

  // Clipping mask of the window, bit 0 being the top row or left column.
  typedef struct packed {
    logic [2:0] rows_in;
    logic [2:0] cols_in;
    logic       row_end;
    logic       frame_end;
  } win_info_t;

  typedef struct packed {
    pix_t            pix;
    logic [COL_W-1:0] col;
    logic            emit;
    win_info_t       info;
  } step_t;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [CNT_W-1:0] n;
    logic             row_end;
    logic             frame_end;
  } sum_t;

  typedef struct packed {
    logic s1_load;
    logic s1_move;
    logic s3_load;
    logic out_load;
  } pipe_ctl_t;

  function automatic logic [EW_W-1:0] eff_width(input logic [DIM_W-1:0] v);
    if (v == '0) return EW_W'(1);
    if (CMPW_W'(v) > CMPW_W'(MAX_WIDTH)) return EW_W'(MAX_WIDTH);
    return EW_W'(v);
  endfunction

  function automatic logic [EH_W-1:0] eff_height(input logic [DIM_W-1:0] v);
    if (v == '0) return EH_W'(1);
    if (CMPH_W'(v) > CMPH_W'(MAX_HEIGHT)) return EH_W'(MAX_HEIGHT);
    return EH_W'(v);
  endfunction

  // Rounded mean (2*sum + n) / (2*n) for n in {1, 2, 3, 4, 6, 9}.  The power of
  // two part of 2*n is a shift; a remaining factor of three or nine is an exact
  // reciprocal multiply over the value range in use.
  function automatic logic [CH_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                               input logic [CNT_W-1:0] n);
    logic [NUM_W-1:0]  num;
    logic [NUM_W-2:0]  half;
    logic [NUM_W-2:0]  quarter;
    logic [NUM_W-2:0]  op3;
    logic [PROD_W-1:0] p3;
    logic [PROD_W-1:0] p9;
    logic [CH_W-1:0]   q;
    num     = {sum, 1'b0} + NUM_W'(n);
    half    = num[NUM_W-1:1];
    quarter = {1'b0, num[NUM_W-1:2]};
    op3     = (n == CNT_W'(6)) ? quarter : half;
    p3      = PROD_W'(op3) * PROD_W'(DIV3_MUL);
    p9      = PROD_W'(half) * PROD_W'(DIV9_MUL);
    case (n)
      CNT_W'(1): q = half[CH_W-1:0];
      CNT_W'(2): q = quarter[CH_W-1:0];
      CNT_W'(4): q = num[CH_W+2:3];
      CNT_W'(3),
      CNT_W'(6): q = p3[DIV3_SH +: CH_W];
      CNT_W'(9): q = p9[DIV9_SH +: CH_W];
      default:   q = '0;
    endcase
    return q;
  endfunction

endpackage

@@ rtl/core/bb3_ctrl.sv @@
// Frame registers, raster counters and per-beat window clipping decisions.
`timescale 1ns / 1ps

module bb3_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          acc,
  input  logic                          in_mode,
  input  bb3_pkg::pix_t                 in_pix,
  output logic                          step_en,
  output bb3_pkg::step_t                step_o
);

  logic [bb3_pkg::DIM_W-1:0]    frame_width_r;
  logic [bb3_pkg::DIM_W-1:0]    frame_height_r;
  logic [bb3_pkg::COL_W-1:0]    in_col_r, in_col_nxt;
  logic [bb3_pkg::IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [bb3_pkg::COL_W-1:0]    out_col_r, out_col_nxt;
  logic [bb3_pkg::ROW_W-1:0]    out_row_r, out_row_nxt;

  logic [bb3_pkg::EW_W-1:0] w;
  logic [bb3_pkg::EH_W-1:0] h;
  logic drain, emit, col_wrap, last_col, last_row;

  assign w        = bb3_pkg::eff_width(frame_width_r);
  assign h        = bb3_pkg::eff_height(frame_height_r);
  assign drain    = in_row_r >= bb3_pkg::IN_ROW_W'(h);
  assign step_en  = drain || (in_mode == bb3_pkg::MODE_PIXEL);
  assign col_wrap = (bb3_pkg::EW_W'(in_col_r) + bb3_pkg::EW_W'(1)) >= w;
  assign emit     = (in_row_r >= bb3_pkg::IN_ROW_W'(2)) ||
                    ((in_row_r == bb3_pkg::IN_ROW_W'(1)) && (in_col_r != '0));
  assign last_col = (bb3_pkg::EW_W'(out_col_r) + bb3_pkg::EW_W'(1)) >= w;
  assign last_row = (bb3_pkg::EH_W'(out_row_r) + bb3_pkg::EH_W'(1)) >= h;

  always_comb begin
    step_o.pix            = drain ? '0 : in_pix;
    step_o.col            = in_col_r;
    step_o.emit           = emit;
    step_o.info.rows_in   = {~last_row, 1'b1, out_row_r != '0};
    step_o.info.cols_in   = {~last_col, 1'b1, out_col_r != '0};
    step_o.info.row_end   = last_col;
    step_o.info.frame_end = last_col && last_row;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc && step_en) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + bb3_pkg::IN_ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + bb3_pkg::COL_W'(1);
      end
      if (emit) begin
        // The last pixel of the frame sends every counter back to the start.
        if (last_col && last_row) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + bb3_pkg::ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + bb3_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::FRAME_DIM_RESET;
      frame_height_r <= bb3_pkg::FRAME_DIM_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

@@ rtl/core/bb3_line_buf.sv @@
// Input register and the two-row line store, held as one wide memory.
`timescale 1ns / 1ps

module bb3_line_buf (
  input  logic               clk,
  input  bb3_pkg::pipe_ctl_t ctl,
  input  bb3_pkg::step_t     step_i,
  output logic               s1_emit,
  output bb3_pkg::win_info_t s1_info,
  output bb3_pkg::col_trip_t trip_o
);

  bb3_pkg::line_ent_t mem [bb3_pkg::MAX_WIDTH];
  bb3_pkg::step_t     s1_r;
  bb3_pkg::line_ent_t rd_r;
  bb3_pkg::line_ent_t fwd_r;
  logic               fwd_hit_r;
  bb3_pkg::line_ent_t cur;
  bb3_pkg::line_ent_t wr;

  // A one-pixel-wide image reads the column written in the same cycle, so the
  // write data is carried across in place of the stale read.
  assign cur       = fwd_hit_r ? fwd_r : rd_r;
  assign wr.older  = cur.newer;
  assign wr.newer  = s1_r.pix;

  always_ff @(posedge clk) begin
    if (ctl.s1_move) begin
      mem[s1_r.col] <= wr;
    end
    if (ctl.s1_load) begin
      rd_r <= mem[step_i.col];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_r      <= step_i;
      fwd_hit_r <= ctl.s1_move && (s1_r.col == step_i.col);
      fwd_r     <= wr;
    end
  end

  assign s1_emit    = s1_r.emit;
  assign s1_info    = s1_r.info;
  assign trip_o.top = cur.older;
  assign trip_o.mid = cur.newer;
  assign trip_o.bot = s1_r.pix;

endmodule

@@ rtl/core/bb3_window_sum.sv @@
// 3x3 window shift register and the clipped per-channel window sums.
`timescale 1ns / 1ps

module bb3_window_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  bb3_pkg::pipe_ctl_t ctl,
  input  bb3_pkg::col_trip_t trip_i,
  input  bb3_pkg::win_info_t info_i,
  output bb3_pkg::sum_t      s3_o
);

  bb3_pkg::pix_t     win_r [3][3];
  bb3_pkg::win_info_t s2_info_r;
  bb3_pkg::sum_t     s3_r;

  logic [bb3_pkg::SUM_W-1:0] red_row   [3];
  logic [bb3_pkg::SUM_W-1:0] green_row [3];
  logic [bb3_pkg::SUM_W-1:0] blue_row  [3];
  logic [bb3_pkg::SUM_W-1:0] red_sum, green_sum, blue_sum;
  logic [1:0]                nr, nc;
  logic [bb3_pkg::CNT_W-1:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (ctl.s1_move) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= trip_i.top;
      win_r[1][2] <= trip_i.mid;
      win_r[2][2] <= trip_i.bot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_move) begin
      s2_info_r <= info_i;
    end
  end

  // Row sums first, then the three rows, to keep the adder chains short.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      red_row[r]   = '0;
      green_row[r] = '0;
      blue_row[r]  = '0;
      for (int c = 0; c < 3; c++) begin
        if (s2_info_r.rows_in[r] && s2_info_r.cols_in[c]) begin
          red_row[r]   = red_row[r]   + bb3_pkg::SUM_W'(win_r[r][c].red);
          green_row[r] = green_row[r] + bb3_pkg::SUM_W'(win_r[r][c].green);
          blue_row[r]  = blue_row[r]  + bb3_pkg::SUM_W'(win_r[r][c].blue);
        end
      end
    end
    red_sum   = red_row[0] + red_row[1] + red_row[2];
    green_sum = green_row[0] + green_row[1] + green_row[2];
    blue_sum  = blue_row[0] + blue_row[1] + blue_row[2];
  end

  assign nr = 2'd1 + 2'(s2_info_r.rows_in[0]) + 2'(s2_info_r.rows_in[2]);
  assign nc = 2'd1 + 2'(s2_info_r.cols_in[0]) + 2'(s2_info_r.cols_in[2]);
  assign n  = bb3_pkg::CNT_W'(nr) * bb3_pkg::CNT_W'(nc);

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      s3_r.red_sum   <= red_sum;
      s3_r.green_sum <= green_sum;
      s3_r.blue_sum  <= blue_sum;
      s3_r.n         <= n;
      s3_r.row_end   <= s2_info_r.row_end;
      s3_r.frame_end <= s2_info_r.frame_end;
    end
  end

  assign s3_o = s3_r;

endmodule

@@ rtl/core/bb3_mean.sv @@
// Rounded mean of each channel sum and the result register.
`timescale 1ns / 1ps

module bb3_mean (
  input  logic                   clk,
  input  bb3_pkg::pipe_ctl_t     ctl,
  input  bb3_pkg::sum_t          s3_i,
  output logic [bb3_pkg::CH_W-1:0] red_out,
  output logic [bb3_pkg::CH_W-1:0] green_out,
  output logic [bb3_pkg::CH_W-1:0] blue_out,
  output logic                   row_end,
  output logic                   frame_end
);

  logic [bb3_pkg::CH_W-1:0] red_r, green_r, blue_r;
  logic                     row_end_r, frame_end_r;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      red_r       <= bb3_pkg::mean_div(s3_i.red_sum, s3_i.n);
      green_r     <= bb3_pkg::mean_div(s3_i.green_sum, s3_i.n);
      blue_r      <= bb3_pkg::mean_div(s3_i.blue_sum, s3_i.n);
      row_end_r   <= s3_i.row_end;
      frame_end_r <= s3_i.frame_end;
    end
  end

  assign red_out   = red_r;
  assign green_out = green_r;
  assign blue_out  = blue_r;
  assign row_end   = row_end_r;
  assign frame_end = frame_end_r;

endmodule

@@ rtl/core/box_blur_3x3_rgb_unit.sv @@
// Path: the beat that completes a window, one row plus one pixel after the pixel it belongs
// to, passes the input register, the window, the sum register and the result register.
// Throughput: one beat per cycle; each stage of the four-deep pipeline moves when the one
// after it is free, and the line store memory takes one read and one write per cycle.
// Reset: frame size registers return to 1024 by 1024, counters and the window clear, and
// the line store is not cleared because only written entries fall inside a clipped window.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bb3_pkg::DATA_W-1:0]    in_tdata,   // red_in, green_in, blue_in
  input  logic                          in_tuser,   // mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bb3_pkg::DATA_W-1:0]    out_tdata,  // red_out, green_out, blue_out
  output logic                          out_tlast,  // row_end
  output logic                          out_tuser,  // frame_end
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0]     cfg_data
);

  bb3_pkg::pix_t      in_pix;
  bb3_pkg::step_t     step;
  bb3_pkg::pipe_ctl_t ctl;
  bb3_pkg::win_info_t s1_info;
  bb3_pkg::col_trip_t trip;
  bb3_pkg::sum_t      s3;
  logic               step_en, acc, s1_emit;
  logic               s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic               s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic               s1_free, s2_free, s3_free, out_free;
  logic [bb3_pkg::CH_W-1:0] red_out, green_out, blue_out;

  assign in_pix.red   = in_tdata[bb3_pkg::CH_W-1:0];
  assign in_pix.green = in_tdata[2*bb3_pkg::CH_W-1:bb3_pkg::CH_W];
  assign in_pix.blue  = in_tdata[3*bb3_pkg::CH_W-1:2*bb3_pkg::CH_W];

  // A stage is free when it is empty or its contents move on this cycle.
  assign out_free  = !out_v_r || out_tready;
  assign s3_free   = !s3_v_r || out_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_tready = s1_free;
  assign acc       = in_tvalid && in_tready;

  assign ctl.s1_load  = acc && step_en;
  assign ctl.s1_move  = s1_v_r && s2_free;
  assign ctl.s3_load  = s2_v_r && s3_free;
  assign ctl.out_load = s3_v_r && out_free;

  // Every step moves the window; only those that complete a window carry a result.
  assign s1_v_nxt  = acc ? step_en : (s1_v_r && !s2_free);
  assign s2_v_nxt  = ctl.s1_move ? s1_emit : (s2_v_r && !s3_free);
  assign s3_v_nxt  = ctl.s3_load || (s3_v_r && !out_free);
  assign out_v_nxt = ctl.out_load || (out_v_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .in_mode   (in_tuser),
    .in_pix    (in_pix),
    .step_en   (step_en),
    .step_o    (step)
  );

  bb3_line_buf u_line_buf (
    .clk     (clk),
    .ctl     (ctl),
    .step_i  (step),
    .s1_emit (s1_emit),
    .s1_info (s1_info),
    .trip_o  (trip)
  );

  bb3_window_sum u_window_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .trip_i (trip),
    .info_i (s1_info),
    .s3_o   (s3)
  );

  bb3_mean u_mean (
    .clk       (clk),
    .ctl       (ctl),
    .s3_i      (s3),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .row_end   (out_tlast),
    .frame_end (out_tuser)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {blue_out, green_out, red_out};

endmodule
